>>> sv/hcls_pkg.sv
// Shared types, codes, constants and scaling functions of the climate and light supervisor.
`timescale 1ns / 1ps

package hcls_pkg;

   // Prescaler timing
   localparam int TICKS_PER_SECOND  = 500;
   localparam int TEMP_SAMPLE_TICK  = 80;
   localparam int LIGHT_SAMPLE_TICK = 240;
   localparam int BUZZ_SECONDS      = 6;

   localparam int TICK_W = $clog2(TICKS_PER_SECOND + 1);
   localparam int BUZZ_W = 3;

   localparam logic [TICK_W-1:0] TICK_WRAP  = TICK_W'(TICKS_PER_SECOND);
   localparam logic [TICK_W-1:0] TICK_TEMP  = TICK_W'(TEMP_SAMPLE_TICK);
   localparam logic [TICK_W-1:0] TICK_LIGHT = TICK_W'(LIGHT_SAMPLE_TICK);
   localparam logic [BUZZ_W-1:0] BUZZ_LAST  = BUZZ_W'(BUZZ_SECONDS);

   // Field widths
   localparam int ACTION_W  = 2;
   localparam int ADC_W     = 10;
   localparam int SECONDS_W = 16;
   localparam int PLAN_W    = 2;
   localparam int CONV_W    = 2;
   localparam int TEMP_W    = 8;
   localparam int LIGHT_W   = 7;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 8;

   typedef logic [ACTION_W-1:0]   action_type;
   typedef logic [PLAN_W-1:0]     plan_type;
   typedef logic [CONV_W-1:0]     conv_type;
   typedef logic [CSR_IDX_W-1:0]  csr_idx_type;

   // Transaction action codes
   localparam action_type ACT_TICK    = 2'd0;
   localparam action_type ACT_ADC     = 2'd1;
   localparam action_type ACT_ARM     = 2'd2;
   localparam action_type ACT_RESTART = 2'd3;

   // Plan codes for lamp and fan
   localparam plan_type PLAN_NONE = 2'd0;
   localparam plan_type PLAN_ON   = 2'd1;
   localparam plan_type PLAN_OFF  = 2'd2;

   // Conversion request codes
   localparam conv_type CONV_NONE  = 2'd0;
   localparam conv_type CONV_TEMP  = 2'd1;
   localparam conv_type CONV_LIGHT = 2'd2;

   // Converter channel codes
   localparam logic CHAN_TEMP  = 1'b0;
   localparam logic CHAN_LIGHT = 1'b1;

   // Register indexes
   localparam csr_idx_type CSR_TEMP_UPPER  = 2'd0;
   localparam csr_idx_type CSR_TEMP_LOWER  = 2'd1;
   localparam csr_idx_type CSR_LIGHT_UPPER = 2'd2;
   localparam csr_idx_type CSR_LIGHT_LOWER = 2'd3;

   localparam logic [10:0] DIV_1023 = 11'd1023;

   // floor(x * 256 / 1023), saturated at 255
   function automatic logic [TEMP_W-1:0] scale_temp(input logic [ADC_W-1:0] x);
      logic [17:0] n;
      logic [7:0]  q0;
      logic [10:0] r;
      logic [8:0]  q;
      n  = {x, 8'b0};
      q0 = n[17:10];
      r  = {1'b0, n[9:0]} + {3'b0, q0};
      q  = {1'b0, q0} + ((r >= DIV_1023) ? 9'd1 : 9'd0);
      scale_temp = q[8] ? 8'hFF : q[7:0];
   endfunction

   // floor(x * 100 / 1023)
   function automatic logic [LIGHT_W-1:0] scale_light(input logic [ADC_W-1:0] x);
      logic [16:0] n;
      logic [6:0]  q0;
      logic [10:0] r;
      n  = {1'b0, x, 6'b0} + {2'b0, x, 5'b0} + {5'b0, x, 2'b0};
      q0 = n[16:10];
      r  = {1'b0, n[9:0]} + {4'b0, q0};
      scale_light = q0 + ((r >= DIV_1023) ? 7'd1 : 7'd0);
   endfunction

endpackage

>>> sv/home_climate_light_supervisor.sv
// Top level of the climate and light supervisor: input register, state update, result register.
`timescale 1ns / 1ps

// Channel   Handshake              Payload
// req       req_valid/req_ready    action, adc_channel, adc_value, arm_seconds, plans
// rsp       rsp_valid/rsp_ready    fan, lamp, buzzer, conversion, mark, timer, readings
// csr       csr_valid/csr_ready    csr_index, csr_wdata (csr_ready always high)
//
// One transaction per cycle while rsp is not stalled; rsp valid rises when the accepted
// transaction moves from the input register to the result register. The state updates
// as it moves, so the next transaction in the input register sees the updated state.
// Reset is synchronous and clears all state and thresholds; no clearing pass.
// A stalled rsp holds the result register; req stays ready while the input register
// can drain into it in the same cycle.

module home_climate_light_supervisor (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [hcls_pkg::ACTION_W-1:0]     req_action,
   input  logic                              req_adc_channel,
   input  logic [hcls_pkg::ADC_W-1:0]        req_adc_value,
   input  logic [hcls_pkg::SECONDS_W-1:0]    req_arm_seconds,
   input  logic [hcls_pkg::PLAN_W-1:0]       req_light_plan,
   input  logic [hcls_pkg::PLAN_W-1:0]       req_fan_plan,
   input  logic                              req_buzzer_plan,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_fan_on,
   output logic                              rsp_light_on,
   output logic                              rsp_buzzer_pin,
   output logic                              rsp_buzzer_active,
   output logic [hcls_pkg::CONV_W-1:0]       rsp_start_conversion,
   output logic                              rsp_second_mark,
   output logic [hcls_pkg::SECONDS_W-1:0]    rsp_seconds_left,
   output logic                              rsp_timer_running,
   output logic [hcls_pkg::TEMP_W-1:0]       rsp_temperature,
   output logic [hcls_pkg::LIGHT_W-1:0]      rsp_light_level,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [hcls_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [hcls_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import hcls_pkg::*;

   // Input register
   logic                  in_valid_ff;
   action_type            in_action_ff;
   logic                  in_channel_ff;
   logic [ADC_W-1:0]      in_adc_ff;
   logic [SECONDS_W-1:0]  in_seconds_ff;
   plan_type              in_light_plan_ff;
   plan_type              in_fan_plan_ff;
   logic                  in_buzzer_plan_ff;

   // Thresholds
   logic [TEMP_W-1:0]     temp_upper_ff;
   logic [TEMP_W-1:0]     temp_lower_ff;
   logic [LIGHT_W-1:0]    light_upper_ff;
   logic [LIGHT_W-1:0]    light_lower_ff;

   // Supervisor state
   logic [TICK_W-1:0]     tick_ff,        tick_in;
   logic [SECONDS_W-1:0]  countdown_ff,   countdown_in;
   logic                  armed_ff,       armed_in;
   plan_type              plan_light_ff,  plan_light_in;
   plan_type              plan_fan_ff,    plan_fan_in;
   logic                  plan_buzz_ff,   plan_buzz_in;
   logic [ADC_W-1:0]      temp_sample_ff, temp_sample_in;
   logic [ADC_W-1:0]      light_sample_ff, light_sample_in;
   logic                  fan_ff,         fan_in;
   logic                  lamp_ff,        lamp_in;
   logic                  buzz_ff,        buzz_in;
   logic                  buzz_level_ff,  buzz_level_in;
   logic [BUZZ_W-1:0]     buzz_sec_ff,    buzz_sec_in;
   logic [TEMP_W-1:0]     temp_scaled_ff, temp_scaled_in;
   logic [LIGHT_W-1:0]    light_scaled_ff, light_scaled_in;
   conv_type              conv_in;
   logic                  mark_in;
   logic [TICK_W-1:0]     tick_inc;

   // Result register
   logic                  rsp_valid_ff;
   logic                  rsp_fan_ff;
   logic                  rsp_lamp_ff;
   logic                  rsp_level_ff;
   logic                  rsp_buzz_ff;
   conv_type              rsp_conv_ff;
   logic                  rsp_mark_ff;
   logic [SECONDS_W-1:0]  rsp_seconds_ff;
   logic                  rsp_armed_ff;
   logic [TEMP_W-1:0]     rsp_temp_ff;
   logic [LIGHT_W-1:0]    rsp_light_ff;

   logic                  advance;
   logic                  req_take;

   // Handshake control
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign req_take  = req_valid && req_ready;
   assign csr_ready = 1'b1;

   // Capture the request transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_take) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
      if (req_take) begin
         in_action_ff      <= req_action;
         in_channel_ff     <= req_adc_channel;
         in_adc_ff         <= req_adc_value;
         in_seconds_ff     <= req_arm_seconds;
         in_light_plan_ff  <= req_light_plan;
         in_fan_plan_ff    <= req_fan_plan;
         in_buzzer_plan_ff <= req_buzzer_plan;
      end
   end

   // Write thresholds
   always_ff @(posedge clock) begin
      if (reset) begin
         temp_upper_ff  <= '0;
         temp_lower_ff  <= '0;
         light_upper_ff <= '0;
         light_lower_ff <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_TEMP_UPPER:  temp_upper_ff  <= csr_wdata[TEMP_W-1:0];
            CSR_TEMP_LOWER:  temp_lower_ff  <= csr_wdata[TEMP_W-1:0];
            CSR_LIGHT_UPPER: light_upper_ff <= csr_wdata[LIGHT_W-1:0];
            CSR_LIGHT_LOWER: light_lower_ff <= csr_wdata[LIGHT_W-1:0];
            default: ;
         endcase
      end
   end

   assign tick_inc = tick_ff + 1'b1;

   // Compute the next state for the held transaction
   always_comb begin
      tick_in         = tick_ff;
      countdown_in    = countdown_ff;
      armed_in        = armed_ff;
      plan_light_in   = plan_light_ff;
      plan_fan_in     = plan_fan_ff;
      plan_buzz_in    = plan_buzz_ff;
      temp_sample_in  = temp_sample_ff;
      light_sample_in = light_sample_ff;
      fan_in          = fan_ff;
      lamp_in         = lamp_ff;
      buzz_in         = buzz_ff;
      buzz_level_in   = buzz_level_ff;
      buzz_sec_in     = buzz_sec_ff;
      temp_scaled_in  = temp_scaled_ff;
      light_scaled_in = light_scaled_ff;
      conv_in         = CONV_NONE;
      mark_in         = 1'b0;

      case (in_action_ff)
         ACT_TICK: begin
            tick_in = tick_inc;
            if (tick_inc == TICK_TEMP) begin
               conv_in = CONV_TEMP;
            end else if (tick_inc == TICK_LIGHT) begin
               conv_in = CONV_LIGHT;
            end
            if (tick_inc >= TICK_WRAP) begin
               tick_in = '0;
               mark_in = 1'b1;

               // Count down; on expiry apply and drop the plans
               if (armed_ff) begin
                  if (countdown_ff != '0) begin
                     countdown_in = countdown_ff - 1'b1;
                  end
                  if (countdown_in == '0) begin
                     armed_in = 1'b0;
                     if (plan_light_ff == PLAN_ON) begin
                        lamp_in = 1'b1;
                     end else if (plan_light_ff == PLAN_OFF) begin
                        lamp_in = 1'b0;
                     end
                     if (plan_fan_ff == PLAN_ON) begin
                        fan_in = 1'b1;
                     end else if (plan_fan_ff == PLAN_OFF) begin
                        fan_in = 1'b0;
                     end
                     if (plan_buzz_ff) begin
                        buzz_in       = 1'b1;
                        buzz_level_in = 1'b1;
                     end
                     plan_light_in = PLAN_NONE;
                     plan_fan_in   = PLAN_NONE;
                     plan_buzz_in  = 1'b0;
                  end
               end

               // Toggle the buzzer and stop it after its run
               if (buzz_in) begin
                  buzz_sec_in   = buzz_sec_ff + 1'b1;
                  buzz_level_in = !buzz_level_in;
                  if (buzz_sec_in >= BUZZ_LAST) begin
                     buzz_in       = 1'b0;
                     buzz_level_in = 1'b0;
                     buzz_sec_in   = '0;
                  end
               end

               // Fan hysteresis on the scaled temperature
               temp_scaled_in = scale_temp(temp_sample_ff);
               if (temp_upper_ff != '0 && temp_lower_ff != '0) begin
                  if (!fan_in && temp_scaled_in > temp_upper_ff) begin
                     fan_in = 1'b1;
                  end else if (fan_in && temp_scaled_in < temp_lower_ff) begin
                     fan_in = 1'b0;
                  end
               end

               // Lamp hysteresis on the light percentage
               light_scaled_in = scale_light(light_sample_ff);
               if (light_upper_ff != '0 && light_lower_ff != '0) begin
                  if (lamp_in && light_scaled_in > light_upper_ff) begin
                     lamp_in = 1'b0;
                  end else if (!lamp_in && light_scaled_in < light_lower_ff) begin
                     lamp_in = 1'b1;
                  end
               end
            end
         end
         ACT_ADC: begin
            if (in_channel_ff == CHAN_TEMP) begin
               temp_sample_in = in_adc_ff;
            end else begin
               light_sample_in = in_adc_ff;
            end
         end
         ACT_ARM: begin
            countdown_in  = in_seconds_ff;
            armed_in      = 1'b1;
            plan_light_in = in_light_plan_ff;
            plan_fan_in   = in_fan_plan_ff;
            plan_buzz_in  = in_buzzer_plan_ff;
         end
         ACT_RESTART: begin
            tick_in = '0;
         end
         default: ;
      endcase
   end

   // Commit the state as the transaction moves on
   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff         <= '0;
         countdown_ff    <= '0;
         armed_ff        <= 1'b0;
         plan_light_ff   <= PLAN_NONE;
         plan_fan_ff     <= PLAN_NONE;
         plan_buzz_ff    <= 1'b0;
         temp_sample_ff  <= '0;
         light_sample_ff <= '0;
         fan_ff          <= 1'b0;
         lamp_ff         <= 1'b0;
         buzz_ff         <= 1'b0;
         buzz_level_ff   <= 1'b0;
         buzz_sec_ff     <= '0;
         temp_scaled_ff  <= '0;
         light_scaled_ff <= '0;
      end else if (advance) begin
         tick_ff         <= tick_in;
         countdown_ff    <= countdown_in;
         armed_ff        <= armed_in;
         plan_light_ff   <= plan_light_in;
         plan_fan_ff     <= plan_fan_in;
         plan_buzz_ff    <= plan_buzz_in;
         temp_sample_ff  <= temp_sample_in;
         light_sample_ff <= light_sample_in;
         fan_ff          <= fan_in;
         lamp_ff         <= lamp_in;
         buzz_ff         <= buzz_in;
         buzz_level_ff   <= buzz_level_in;
         buzz_sec_ff     <= buzz_sec_in;
         temp_scaled_ff  <= temp_scaled_in;
         light_scaled_ff <= light_scaled_in;
      end
   end

   // Load the result register, hold it while stalled
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (advance) begin
         rsp_fan_ff     <= fan_in;
         rsp_lamp_ff    <= lamp_in;
         rsp_level_ff   <= buzz_level_in;
         rsp_buzz_ff    <= buzz_in;
         rsp_conv_ff    <= conv_in;
         rsp_mark_ff    <= mark_in;
         rsp_seconds_ff <= countdown_in;
         rsp_armed_ff   <= armed_in;
         rsp_temp_ff    <= temp_scaled_in;
         rsp_light_ff   <= light_scaled_in;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_fan_on           = rsp_fan_ff;
   assign rsp_light_on         = rsp_lamp_ff;
   assign rsp_buzzer_pin       = rsp_level_ff;
   assign rsp_buzzer_active    = rsp_buzz_ff;
   assign rsp_start_conversion = rsp_conv_ff;
   assign rsp_second_mark      = rsp_mark_ff;
   assign rsp_seconds_left     = rsp_seconds_ff;
   assign rsp_timer_running    = rsp_armed_ff;
   assign rsp_temperature      = rsp_temp_ff;
   assign rsp_light_level      = rsp_light_ff;

   // A disarmed timer always rests at zero
   a_idle_timer_zero: assert property (@(posedge clock) disable iff (reset)
      !armed_ff |-> countdown_ff == '0)
      else $error("disarmed countdown is nonzero");

   // An idle buzzer keeps its pin low and its count clear
   a_idle_buzzer: assert property (@(posedge clock) disable iff (reset)
      !buzz_ff |-> (!buzz_level_ff && buzz_sec_ff == '0))
      else $error("idle buzzer left pin or count set");

   // The buzzer count stops before the end of its run
   a_buzz_count: assert property (@(posedge clock) disable iff (reset)
      buzz_sec_ff < BUZZ_LAST)
      else $error("buzzer second count overran");

   // The prescaler wraps before reaching a full second
   a_tick_range: assert property (@(posedge clock) disable iff (reset)
      tick_ff < TICK_WRAP)
      else $error("tick prescaler overran");

   // A second mark in the result comes only from a base tick
   a_mark_from_tick: assert property (@(posedge clock) disable iff (reset)
      (advance && in_action_ff != ACT_TICK) |=> !rsp_mark_ff)
      else $error("second mark on a non-tick transaction");

endmodule

>>> test/tb_home_climate_light_supervisor.sv
// Testbench for the climate and light supervisor: self-predicting driver, checker and tests.
`timescale 1ns / 1ps

module tb_home_climate_light_supervisor;
   import hcls_pkg::*;

   localparam int LIMIT_CYCLES  = 6_000_000;
   localparam int RANDOM_EVENTS = 1250;
   localparam int EPISODE_EVENTS = 150;

   // Plan code with no defined action
   localparam plan_type PLAN_UNUSED = 2'd3;

   typedef struct {
      action_type       action;
      logic             chan;
      logic [ADC_W-1:0] value;
      logic [15:0]      secs;
      plan_type         lamp_plan;
      plan_type         fan_plan;
      logic             buzz_plan;
   } climate_event_type;

   typedef struct {
      logic        fan;
      logic        lamp;
      logic        pin;
      logic        buzzing;
      conv_type    conv;
      logic        mark;
      logic [15:0] left;
      logic        running;
      logic [7:0]  temp;
      logic [6:0]  light;
   } supervisor_status_type;

   // Clock, reset and ports
   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  req_valid = 1'b0;
   logic                  req_ready;
   action_type            req_action = ACT_TICK;
   logic                  req_adc_channel = CHAN_TEMP;
   logic [ADC_W-1:0]      req_adc_value = '0;
   logic [SECONDS_W-1:0]  req_arm_seconds = '0;
   plan_type              req_light_plan = PLAN_NONE;
   plan_type              req_fan_plan = PLAN_NONE;
   logic                  req_buzzer_plan = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic                  rsp_fan_on;
   logic                  rsp_light_on;
   logic                  rsp_buzzer_pin;
   logic                  rsp_buzzer_active;
   conv_type              rsp_start_conversion;
   logic                  rsp_second_mark;
   logic [SECONDS_W-1:0]  rsp_seconds_left;
   logic                  rsp_timer_running;
   logic [TEMP_W-1:0]     rsp_temperature;
   logic [LIGHT_W-1:0]    rsp_light_level;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   csr_idx_type           csr_index = CSR_TEMP_UPPER;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // Supervisor state as the testbench predicts it
   logic [8:0]  tick_pos = '0;
   logic [15:0] countdown_left = '0;
   logic        countdown_on = 1'b0;
   plan_type    lamp_plan_held = PLAN_NONE;
   plan_type    fan_plan_held = PLAN_NONE;
   logic        buzz_plan_held = 1'b0;
   logic [9:0]  temp_raw = '0;
   logic [9:0]  light_raw = '0;
   logic        fan_drive = 1'b0;
   logic        lamp_drive = 1'b0;
   logic        buzz_on = 1'b0;
   logic        buzz_level = 1'b0;
   logic [2:0]  buzz_count = '0;
   logic [7:0]  temp_reading = '0;
   logic [6:0]  light_reading = '0;
   logic [7:0]  fan_hi = '0;
   logic [7:0]  fan_lo = '0;
   logic [6:0]  lamp_hi = '0;
   logic [6:0]  lamp_lo = '0;
   conv_type    last_request = CONV_NONE;

   supervisor_status_type expected_status_q[$];
   int    errors = 0;
   int    checked = 0;
   int    seconds_seen = 0;
   int    expiries = 0;
   int    csr_writes = 0;
   int    stall_left = 0;
   bit    no_idle = 1'b0;
   longint cycles = 0;

   home_climate_light_supervisor uut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_action           (req_action),
      .req_adc_channel      (req_adc_channel),
      .req_adc_value        (req_adc_value),
      .req_arm_seconds      (req_arm_seconds),
      .req_light_plan       (req_light_plan),
      .req_fan_plan         (req_fan_plan),
      .req_buzzer_plan      (req_buzzer_plan),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_fan_on           (rsp_fan_on),
      .rsp_light_on         (rsp_light_on),
      .rsp_buzzer_pin       (rsp_buzzer_pin),
      .rsp_buzzer_active    (rsp_buzzer_active),
      .rsp_start_conversion (rsp_start_conversion),
      .rsp_second_mark      (rsp_second_mark),
      .rsp_seconds_left     (rsp_seconds_left),
      .rsp_timer_running    (rsp_timer_running),
      .rsp_temperature      (rsp_temperature),
      .rsp_light_level      (rsp_light_level),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata)
   );

   always #2 clock = ~clock;

   // Abort a hung run
   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT_CYCLES) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // One-second update: countdown, expiry, buzzer, scaling and hysteresis
   function automatic void advance_second();
      int unsigned scaled;
      seconds_seen++;
      if (countdown_on) begin
         if (countdown_left != 16'd0) countdown_left = countdown_left - 16'd1;
         if (countdown_left == 16'd0) begin
            countdown_on = 1'b0;
            expiries++;
            if (lamp_plan_held == PLAN_ON) lamp_drive = 1'b1;
            else if (lamp_plan_held == PLAN_OFF) lamp_drive = 1'b0;
            if (fan_plan_held == PLAN_ON) fan_drive = 1'b1;
            else if (fan_plan_held == PLAN_OFF) fan_drive = 1'b0;
            if (buzz_plan_held) begin
               buzz_on = 1'b1;
               buzz_level = 1'b1;
            end
            lamp_plan_held = PLAN_NONE;
            fan_plan_held = PLAN_NONE;
            buzz_plan_held = 1'b0;
         end
      end

      if (buzz_on) begin
         buzz_count = buzz_count + 3'd1;
         buzz_level = ~buzz_level;
         if (buzz_count >= BUZZ_SECONDS) begin
            buzz_on = 1'b0;
            buzz_level = 1'b0;
            buzz_count = 3'd0;
         end
      end

      scaled = (temp_raw * 256) / 1023;
      temp_reading = (scaled > 255) ? 8'd255 : 8'(scaled);
      if (fan_hi != 8'd0 && fan_lo != 8'd0) begin
         if (!fan_drive && temp_reading > fan_hi) fan_drive = 1'b1;
         else if (fan_drive && temp_reading < fan_lo) fan_drive = 1'b0;
      end

      scaled = (light_raw * 100) / 1023;
      light_reading = 7'(scaled);
      if (lamp_hi != 7'd0 && lamp_lo != 7'd0) begin
         if (lamp_drive && light_reading > lamp_hi) lamp_drive = 1'b0;
         else if (!lamp_drive && light_reading < lamp_lo) lamp_drive = 1'b1;
      end
   endfunction

   // Advance the predicted state by one accepted transaction
   function automatic supervisor_status_type predict_status(climate_event_type ev);
      supervisor_status_type st;
      st.conv = CONV_NONE;
      st.mark = 1'b0;
      case (ev.action)
         ACT_TICK: begin
            tick_pos = tick_pos + 9'd1;
            if (tick_pos == TEMP_SAMPLE_TICK) st.conv = CONV_TEMP;
            else if (tick_pos == LIGHT_SAMPLE_TICK) st.conv = CONV_LIGHT;
            if (tick_pos >= TICKS_PER_SECOND) begin
               tick_pos = 9'd0;
               st.mark = 1'b1;
               advance_second();
            end
         end
         ACT_ADC: begin
            if (ev.chan == CHAN_TEMP) temp_raw = ev.value;
            else light_raw = ev.value;
         end
         ACT_ARM: begin
            countdown_left = ev.secs;
            countdown_on = 1'b1;
            lamp_plan_held = ev.lamp_plan;
            fan_plan_held = ev.fan_plan;
            buzz_plan_held = ev.buzz_plan;
         end
         ACT_RESTART: tick_pos = 9'd0;
         default: ;
      endcase
      last_request = st.conv;
      st.fan = fan_drive;
      st.lamp = lamp_drive;
      st.pin = buzz_level;
      st.buzzing = buzz_on;
      st.left = countdown_left;
      st.running = countdown_on;
      st.temp = temp_reading;
      st.light = light_reading;
      return st;
   endfunction

   task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         errors++;
      end
   endtask

   task automatic check_status();
      supervisor_status_type want;
      if (expected_status_q.size() == 0) begin
         $error("result arrived with no transaction pending");
         errors++;
      end else begin
         want = expected_status_q.pop_front();
         checked++;
         check_field("fan_on", want.fan, rsp_fan_on);
         check_field("light_on", want.lamp, rsp_light_on);
         check_field("buzzer_pin", want.pin, rsp_buzzer_pin);
         check_field("buzzer_active", want.buzzing, rsp_buzzer_active);
         check_field("start_conversion", want.conv, rsp_start_conversion);
         check_field("second_mark", want.mark, rsp_second_mark);
         check_field("seconds_left", want.left, rsp_seconds_left);
         check_field("timer_running", want.running, rsp_timer_running);
         check_field("temperature", want.temp, rsp_temperature);
         check_field("light_level", want.light, rsp_light_level);
      end
   endtask

   // Check each result and draw the stall before the next one
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
         check_status();
         stall_left = no_idle ? 0 : $urandom_range(0, 7);
      end else if (stall_left > 0) begin
         stall_left--;
      end
   end

   always @(negedge clock) rsp_ready <= (stall_left == 0);

   // Drive one transaction after a random gap and record its expected result
   task automatic send_event(climate_event_type ev);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 7);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_action <= ev.action;
      req_adc_channel <= ev.chan;
      req_adc_value <= ev.value;
      req_arm_seconds <= ev.secs;
      req_light_plan <= ev.lamp_plan;
      req_fan_plan <= ev.fan_plan;
      req_buzzer_plan <= ev.buzz_plan;
      do @(posedge clock); while (!req_ready);
      expected_status_q.push_back(predict_status(ev));
   endtask

   // Fill the fields that the action ignores with random bits
   function automatic climate_event_type noise_fields(action_type action);
      climate_event_type ev;
      ev.action = action;
      ev.chan = 1'($urandom);
      ev.value = 10'($urandom);
      ev.secs = 16'($urandom);
      ev.lamp_plan = plan_type'($urandom);
      ev.fan_plan = plan_type'($urandom);
      ev.buzz_plan = 1'($urandom);
      return ev;
   endfunction

   task automatic send_tick();
      send_event(noise_fields(ACT_TICK));
   endtask

   task automatic send_restart();
      send_event(noise_fields(ACT_RESTART));
   endtask

   task automatic send_adc(logic chan, logic [9:0] value);
      climate_event_type ev;
      ev = noise_fields(ACT_ADC);
      ev.chan = chan;
      ev.value = value;
      send_event(ev);
   endtask

   task automatic send_arm(logic [15:0] secs, plan_type lamp, plan_type fan, logic buzz);
      climate_event_type ev;
      ev = noise_fields(ACT_ARM);
      ev.secs = secs;
      ev.lamp_plan = lamp;
      ev.fan_plan = fan;
      ev.buzz_plan = buzz;
      send_event(ev);
   endtask

   task automatic run_ticks(int count);
      repeat (count) send_tick();
   endtask

   task automatic run_to_second();
      repeat (TICKS_PER_SECOND - tick_pos) send_tick();
   endtask

   task automatic run_seconds(int count);
      repeat (count) run_to_second();
   endtask

   // Drop valid and wait until every expected result has been checked
   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_status_q.size() != 0) @(posedge clock);
   endtask

   task automatic write_threshold(csr_idx_type idx, logic [7:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_TEMP_UPPER:  fan_hi = value;
         CSR_TEMP_LOWER:  fan_lo = value;
         CSR_LIGHT_UPPER: lamp_hi = value[6:0];
         CSR_LIGHT_LOWER: lamp_lo = value[6:0];
         default: ;
      endcase
      csr_writes++;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_thresholds(logic [7:0] t_up, logic [7:0] t_lo,
                                 logic [7:0] l_up, logic [7:0] l_lo);
      settle();
      write_threshold(CSR_TEMP_UPPER, t_up);
      write_threshold(CSR_TEMP_LOWER, t_lo);
      write_threshold(CSR_LIGHT_UPPER, l_up);
      write_threshold(CSR_LIGHT_LOWER, l_lo);
   endtask

   function automatic logic [7:0] pick_threshold(int unsigned top);
      case ($urandom_range(0, 9))
         0, 1: return 8'd0;
         2: return 8'(top);
         default: return 8'($urandom_range(1, top));
      endcase
   endfunction

   function automatic logic [9:0] pick_sample();
      case ($urandom_range(0, 7))
         0: return 10'd0;
         1: return 10'd1023;
         default: return 10'($urandom);
      endcase
   endfunction

   function automatic plan_type pick_plan();
      if ($urandom_range(0, 7) == 0) return PLAN_UNUSED;
      return plan_type'($urandom_range(0, 2));
   endfunction

   function automatic logic [15:0] pick_countdown();
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return 16'd0;
         8: return 16'($urandom);
         9: return 16'hFFFF;
         default: return 16'($urandom_range(1, 3));
      endcase
   endfunction

   // Transactions straight out of reset, before any second has passed
   task automatic test_power_on();
      send_restart();
      send_adc(CHAN_TEMP, 10'h2AA);
      send_adc(CHAN_LIGHT, 10'h155);
      run_ticks(3);
      send_restart();
      settle();
   endtask

   // Conversion requests at their ticks, saturated and zero readings
   task automatic test_sample_requests();
      send_restart();
      run_ticks(TEMP_SAMPLE_TICK);
      send_adc(CHAN_TEMP, 10'd1023);
      run_ticks(LIGHT_SAMPLE_TICK - TEMP_SAMPLE_TICK);
      send_adc(CHAN_LIGHT, 10'd1023);
      run_to_second();
      send_adc(CHAN_TEMP, 10'd1022);
      send_adc(CHAN_LIGHT, 10'd0);
      run_to_second();
      send_adc(CHAN_TEMP, 10'd0);
      run_to_second();
      settle();
   endtask

   // Restart the prescaler just before the wrap and back to back
   task automatic test_prescaler_restart();
      no_idle = 1'b1;
      run_ticks(TICKS_PER_SECOND - 1);
      no_idle = 1'b0;
      send_restart();
      send_restart();
      run_ticks(TEMP_SAMPLE_TICK);
      send_restart();
      run_to_second();
      settle();
   endtask

   // Arm with zero, full range, rearm, unused plan code and buzzer retrigger
   task automatic test_countdown();
      send_arm(16'd0, PLAN_ON, PLAN_ON, 1'b1);
      run_seconds(BUZZ_SECONDS + 1);
      send_arm(16'd2, PLAN_OFF, PLAN_OFF, 1'b0);
      run_seconds(2);
      send_arm(16'hFFFF, PLAN_ON, PLAN_NONE, 1'b1);
      run_seconds(1);
      send_arm(16'd1, PLAN_UNUSED, PLAN_ON, 1'b0);
      run_seconds(2);
      send_arm(16'd0, PLAN_NONE, PLAN_UNUSED, 1'b1);
      run_seconds(2);
      send_arm(16'd0, PLAN_NONE, PLAN_NONE, 1'b1);
      run_seconds(BUZZ_SECONDS + 1);
      settle();
   endtask

   // Walk fan and lamp through their thresholds, extremes and disabled pairs
   task automatic test_hysteresis();
      set_thresholds(8'd100, 8'd50, 8'd60, 8'd20);
      send_adc(CHAN_TEMP, 10'd1023);
      send_adc(CHAN_LIGHT, 10'd0);
      run_to_second();
      send_adc(CHAN_TEMP, 10'd300);
      send_adc(CHAN_LIGHT, 10'd500);
      run_to_second();
      send_adc(CHAN_TEMP, 10'd150);
      send_adc(CHAN_LIGHT, 10'd900);
      run_to_second();

      set_thresholds(8'd255, 8'd255, 8'd100, 8'd100);
      send_adc(CHAN_TEMP, 10'd1023);
      send_adc(CHAN_LIGHT, 10'd1023);
      run_to_second();
      send_adc(CHAN_LIGHT, 10'd1022);
      run_to_second();

      set_thresholds(8'd1, 8'd1, 8'd1, 8'd1);
      send_adc(CHAN_TEMP, 10'd4);
      run_to_second();
      send_adc(CHAN_TEMP, 10'd8);
      send_adc(CHAN_LIGHT, 10'd20);
      run_to_second();
      send_adc(CHAN_TEMP, 10'd0);
      run_to_second();

      set_thresholds(8'd200, 8'd0, 8'd0, 8'd50);
      send_adc(CHAN_TEMP, 10'd1023);
      send_adc(CHAN_LIGHT, 10'd0);
      run_to_second();
      settle();
   endtask

   // Tick trains with converter answers, arms, stray readings and restarts
   task automatic test_random_operation();
      int sent;
      int pick;
      int next_thresholds;
      sent = 0;
      next_thresholds = 0;
      while (sent < RANDOM_EVENTS) begin
         if (sent >= next_thresholds) begin
            set_thresholds(pick_threshold(255), pick_threshold(255),
                           pick_threshold(100), pick_threshold(100));
            next_thresholds = next_thresholds + EPISODE_EVENTS;
         end
         if ($urandom_range(0, 79) != 0) begin
            send_tick();
            sent++;
            if (tick_pos == 0) no_idle = ($urandom_range(0, 3) == 0);
            // Answer most conversion requests on the requested channel
            if (last_request != CONV_NONE && $urandom_range(0, 4) != 0) begin
               send_adc((last_request == CONV_TEMP) ? CHAN_TEMP : CHAN_LIGHT, pick_sample());
               sent++;
            end
         end else begin
            pick = $urandom_range(0, 99);
            if (pick < 55) send_adc(1'($urandom), pick_sample());
            else if (pick < 92) send_arm(pick_countdown(), pick_plan(), pick_plan(),
                                         1'($urandom));
            else send_restart();
            sent++;
         end
      end
      no_idle = 1'b0;
      settle();
   endtask

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_power_on();
      test_sample_requests();
      test_prescaler_restart();
      test_countdown();
      test_hysteresis();
      test_random_operation();

      settle();
      repeat (8) @(posedge clock);
      $display("Checked %0d results over %0d simulated seconds with %0d timer expiries,",
               checked, seconds_seen, expiries);
      $display("%0d threshold writes and randomized idle on both channels.", csr_writes);
      if (errors == 0 && expected_status_q.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
